// ----- rtl/deque_with_positional_insert_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the deque with positional insert
// Clocked assertion wrappers; compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_POSITIONAL_INSERT_UNIT_DEFINES_SVH
`define DEQUE_WITH_POSITIONAL_INSERT_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define DQPI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define DQPI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DQPI_ASSERT(lbl, clk, rst_n, prop, msg)
`define DQPI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/dqpi_pkg.sv -----
// ----------------------------------------------------------------------------
// dqpi_pkg
// Shared codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dqpi_pkg;

    // input mode codes
    localparam logic [1:0] MODE_ADD_FRONT = 2'd0;
    localparam logic [1:0] MODE_ADD_END   = 2'd1;
    localparam logic [1:0] MODE_ADD_AT    = 2'd2;
    localparam logic [1:0] MODE_REMOVE    = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    // datapath operations
    localparam logic [2:0] OP_NONE       = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_PUSH_END   = 3'd2;
    localparam logic [2:0] OP_PUSH_AT    = 3'd3;
    localparam logic [2:0] OP_POP        = 3'd4;

    typedef struct packed {
        logic       load;    // transaction accepted: update store and result
        logic [2:0] op;
        logic [1:0] status;
    } t_dqpi_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_dqpi_stat;

endpackage

// ----- rtl/dqpi_ctrl.sv -----
// ----------------------------------------------------------------------------
// dqpi_ctrl
// Handshake FSM and operation decode for the deque.
// ----------------------------------------------------------------------------
module dqpi_ctrl import dqpi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    input  logic [1:0]        i_mode,
    input  logic signed [31:0] i_position,
    input  t_dqpi_stat        i_stat,
    output t_dqpi_cmd         o_cmd
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_RESULT = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;
    logic bad_pos;

    assign o_ready = (r_state == S_IDLE) || i_ready;
    assign o_valid = (r_state == S_RESULT);
    assign accept  = i_valid && o_ready;
    assign bad_pos = (i_position == 32'sd0) || i_position[31];

    always_comb begin
        n_state = r_state;
        if (accept) begin
            n_state = S_RESULT;
        end else if (i_ready) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // position check precedes the full check
    always_comb begin
        o_cmd.load   = accept;
        o_cmd.op     = OP_NONE;
        o_cmd.status = ST_OK;
        priority if (i_mode == MODE_REMOVE) begin
            if (i_stat.empty) begin
                o_cmd.status = ST_EMPTY;
            end else begin
                o_cmd.op = OP_POP;
            end
        end else if (i_mode == MODE_ADD_AT && bad_pos) begin
            o_cmd.status = ST_BADPOS;
        end else if (i_stat.full) begin
            o_cmd.status = ST_FULL;
        end else if (i_mode == MODE_ADD_FRONT) begin
            o_cmd.op = OP_PUSH_FRONT;
        end else if (i_mode == MODE_ADD_END) begin
            o_cmd.op = OP_PUSH_END;
        end else begin
            o_cmd.op = OP_PUSH_AT;
        end
    end

endmodule

// ----- rtl/dqpi_dpath.sv -----
// ----------------------------------------------------------------------------
// dqpi_dpath
// Row of ID cells with local hold/shift/load, fill count and result regs.
// ----------------------------------------------------------------------------
module dqpi_dpath import dqpi_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dqpi_cmd         i_cmd,
    input  logic [31:0]       i_id,
    input  logic [31:0]       i_position,
    output t_dqpi_stat        o_stat,
    output logic [1:0]        o_status,
    output logic [31:0]       o_removed_id,
    output logic [4:0]        o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [31:0]   r_cells [DEPTH];
    logic [31:0]   n_cells [DEPTH];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] ins_idx;
    logic [31:0]   pos_m1;
    logic          is_push;
    logic          is_pop;

    logic [1:0]    r_status;
    logic [31:0]   r_removed;
    logic [CW-1:0] r_count_out;

    assign is_push = i_cmd.load && (i_cmd.op == OP_PUSH_FRONT || i_cmd.op == OP_PUSH_END
                                    || i_cmd.op == OP_PUSH_AT);
    assign is_pop  = i_cmd.load && (i_cmd.op == OP_POP);
    assign pos_m1  = i_position - 32'd1;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));

    // insert index: 0 for front, count for end, min(position - 1, count) for positional insert
    always_comb begin
        unique case (i_cmd.op)
            OP_PUSH_FRONT: ins_idx = '0;
            OP_PUSH_AT:    ins_idx = (pos_m1 >= 32'(r_count)) ? r_count : pos_m1[CW-1:0];
            default:       ins_idx = r_count;
        endcase
    end

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [31:0] left_src;   // neighbor toward the front
        logic [31:0] right_src;  // neighbor toward the end
        if (gi == 0) begin : g_first
            assign left_src = r_cells[gi];
        end else begin : g_mid
            assign left_src = r_cells[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign right_src = r_cells[gi];
        end else begin : g_notlast
            assign right_src = r_cells[gi+1];
        end

        always_comb begin
            n_cells[gi] = r_cells[gi];
            if (is_push) begin
                if (CW'(gi) == ins_idx) begin
                    n_cells[gi] = i_id;
                end else if (CW'(gi) > ins_idx) begin
                    n_cells[gi] = left_src;
                end
            end else if (is_pop) begin
                n_cells[gi] = right_src;
            end
        end

        always_ff @(posedge i_clk) begin
            r_cells[gi] <= n_cells[gi];
        end
    end

    always_comb begin
        n_count = r_count;
        if (is_push) begin
            n_count = r_count + CW'(1);
        end else if (is_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result registers hold until the next transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status    <= i_cmd.status;
            r_removed   <= is_pop ? r_cells[0] : 32'd0;
            r_count_out <= n_count;
        end
    end

    assign o_status      = r_status;
    assign o_removed_id  = r_removed;
    assign o_entry_count = 5'(r_count_out);

endmodule

// ----- rtl/deque_with_positional_insert_unit.sv -----
// Result: an accepted transaction's result appears on o_valid in the cycle after it is accepted.
// Throughput: one transaction per cycle while i_ready is high; the next input is taken in the same
//   cycle that the pending result is taken, set by the single result register.
// Reset: synchronous, active low; clears the fill count and the handshake
//   state. ID cells are not reset; cells at or beyond the count are never read.
// ----------------------------------------------------------------------------
// deque_with_positional_insert_unit
// Bounded deque of 32-bit IDs: push front, push end, insert at 1-based
// position, pop front. One result per transaction: status, popped ID, count.
// ----------------------------------------------------------------------------
`include "deque_with_positional_insert_unit_defines.svh"

module deque_with_positional_insert_unit import dqpi_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_patient_id,
    input  logic signed [31:0] i_position,
    // result channel
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_removed_id,
    output logic [4:0]         o_entry_count
);

    t_dqpi_cmd  cmd;
    t_dqpi_stat stat;

    // Controller: owns the handshake and decodes mode + flags into a command.
    // A transaction is taken whenever no result is pending or the pending
    // one leaves in the same cycle.
    dqpi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .i_mode     (i_mode),
        .i_position (i_position),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Datapath: each cell holds, shifts toward the end (insert), shifts
    // toward the front (pop) or loads the new ID.
    dqpi_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_id          (i_patient_id),
        .i_position    (i_position),
        .o_stat        (stat),
        .o_status      (o_status),
        .o_removed_id  (o_removed_id),
        .o_entry_count (o_entry_count)
    );

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `DQPI_ASSERT(a_accept_gives_result, i_clk, i_rst_n, (i_valid && o_ready) |=> o_valid, "accepted transaction produced no result")
    `DQPI_ASSERT(a_full_count, i_clk, i_rst_n, (o_valid && o_status == ST_FULL) |-> (o_entry_count == 5'(DEPTH)), "full status with count below depth")
    `DQPI_ASSERT(a_empty_result, i_clk, i_rst_n, (o_valid && o_status == ST_EMPTY) |-> (o_entry_count == 5'd0 && o_removed_id == 32'sd0), "empty status with nonzero count or ID")
    `DQPI_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

// ----- tb/sv/deque_with_positional_insert_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_with_positional_insert_unit_test
// Self-checking bench for the bounded ID deque. It runs a directed table
// (empty pop, bad positions, full refusals, front/end/positional inserts),
// then about 1250 random transactions under three idle mixes on the two
// valid/ready channels. Each result is checked against a local deque model or a typed-in expectation.
// ----------------------------------------------------------------------------
module deque_with_positional_insert_unit_test;
    import dqpi_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1250;
    localparam int SWEEP_LEN    = 48;    // transactions per fill or drain sweep
    localparam int DRAIN_CYCLES = 8;     // settle time after the last result

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_id;
        logic [4:0]         entry_count;
    } t_deque_result;

    // one row of the directed table; reps repeats the same transaction
    typedef struct {
        logic [1:0]         mode;
        logic signed [31:0] id;
        logic signed [31:0] pos;
        int                 reps;
        bit                 has_fixed;
        t_deque_result      fixed;
    } t_stim_row;

    // DUT ports; the inputs are all known from time zero
    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_valid      = 1'b0;
    logic               o_ready;
    logic [1:0]         i_mode       = MODE_ADD_FRONT;
    logic signed [31:0] i_patient_id = '0;
    logic signed [31:0] i_position   = '0;
    logic               o_valid;
    logic               i_ready      = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_removed_id;
    logic [4:0]         o_entry_count;

    // typed-in expectation that travels with the payload of a directed row
    bit                 fixed_result_en = 1'b0;
    t_deque_result      fixed_result    = '0;

    // deque model state
    logic signed [31:0] model_ids [QUEUE_DEPTH];
    int                 model_count = 0;

    t_deque_result      expected_results [$];
    t_stim_row          directed_rows [$];
    int                 mismatch_count = 0;
    int                 send_idle_pct  = 0;
    int                 recv_idle_pct  = 0;

    deque_with_positional_insert_unit #(
        .DEPTH(QUEUE_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_patient_id  (i_patient_id),
        .i_position    (i_position),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_removed_id  (o_removed_id),
        .o_entry_count (o_entry_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Apply one transaction to the model deque and return the result it gives.
    // Bad position is checked before full; a position past the end appends.
    function automatic t_deque_result apply_deque_op(input logic [1:0] mode,
                                                     input logic signed [31:0] id,
                                                     input logic signed [31:0] pos);
        t_deque_result res;
        int            slot;
        int            k;
        res = '0;
        res.status = ST_OK;
        if (mode == MODE_REMOVE) begin
            if (model_count == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.removed_id = model_ids[0];
                for (k = 0; k < QUEUE_DEPTH - 1; k++)
                    model_ids[k] = model_ids[k + 1];
                model_count--;
            end
        end else if (mode == MODE_ADD_AT && pos <= 0) begin
            res.status = ST_BADPOS;
        end else if (model_count >= QUEUE_DEPTH) begin
            res.status = ST_FULL;
        end else begin
            case (mode)
                MODE_ADD_FRONT: slot = 0;
                MODE_ADD_END:   slot = model_count;
                default:        slot = (pos - 1 > model_count) ? model_count : pos - 1;
            endcase
            for (k = QUEUE_DEPTH - 1; k > slot; k--)
                model_ids[k] = model_ids[k - 1];
            model_ids[slot] = id;
            model_count++;
        end
        res.entry_count = model_count[4:0];
        return res;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    // Check the result channel first, then log the input transaction, so a
    // result never meets an expectation queued at the same edge.
    always @(posedge i_clk) begin
        t_deque_result want;
        t_deque_result model_res;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    log_mismatch($sformatf("t=%0t result with none expected: st=%0d id=%0d cnt=%0d",
                                           $time, o_status, o_removed_id, o_entry_count));
                end else begin
                    want = expected_results.pop_front();
                    if (o_status !== want.status)
                        log_mismatch($sformatf("t=%0t status: exp %0d act %0d",
                                               $time, want.status, o_status));
                    if (o_removed_id !== want.removed_id)
                        log_mismatch($sformatf("t=%0t removed_id: exp %0d act %0d",
                                               $time, want.removed_id, o_removed_id));
                    if (o_entry_count !== want.entry_count)
                        log_mismatch($sformatf("t=%0t entry_count: exp %0d act %0d",
                                               $time, want.entry_count, o_entry_count));
                end
            end
            if (i_valid && o_ready) begin
                // model always advances; a typed-in row overrides its prediction
                model_res = apply_deque_op(i_mode, i_patient_id, i_position);
                expected_results.push_back(fixed_result_en ? fixed_result : model_res);
            end
        end
    end

    // result side back-pressure
    always @(posedge i_clk)
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Present one transaction and hold it until accepted. Idle cycles go in
    // front of it, so valid only drops between transactions.
    task automatic send_request(input logic [1:0] mode, input logic signed [31:0] id,
                                input logic signed [31:0] pos, input bit has_fixed,
                                input t_deque_result fixed);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_mode          <= mode;
        i_patient_id    <= id;
        i_position      <= pos;
        fixed_result_en <= has_fixed;
        fixed_result    <= fixed;
        i_valid         <= 1'b1;
        do
            @(posedge i_clk);
        while (!o_ready);
    endtask

    task automatic add_row(input logic [1:0] mode, input logic signed [31:0] id,
                           input logic signed [31:0] pos, input int reps,
                           input bit has_fixed, input logic [1:0] status,
                           input logic signed [31:0] removed, input logic [4:0] count);
        t_stim_row row;
        row.mode                    = mode;
        row.id                      = id;
        row.pos                     = pos;
        row.reps                    = reps;
        row.has_fixed               = has_fixed;
        row.fixed.status            = status;
        row.fixed.removed_id        = removed;
        row.fixed.entry_count       = count;
        directed_rows.push_back(row);
    endtask

    initial begin
        int                 n;
        int                 r;
        int                 roll;
        bit                 filling;
        logic [1:0]         mode;
        logic signed [31:0] pos;
        t_stim_row          row;

        // directed table: mode, id, position, repeats, typed?, status, popped, count
        add_row(MODE_REMOVE,    32'sd0,           32'sd0,           1, 1, ST_EMPTY,  0, 0);
        add_row(MODE_ADD_AT,    32'sd11,          32'sd0,           1, 1, ST_BADPOS, 0, 0);
        add_row(MODE_ADD_AT,    32'sd12,          32'sh8000_0000,   1, 1, ST_BADPOS, 0, 0);
        add_row(MODE_ADD_FRONT, 32'sh7fff_ffff,   32'sd0,           1, 1, ST_OK,     0, 1);
        add_row(MODE_ADD_END,   32'sh8000_0000,   32'sh7fff_ffff,   1, 1, ST_OK,     0, 2);
        // position 1 goes to the front
        add_row(MODE_ADD_AT,    32'shffff_ffff,   32'sd1,           1, 0, ST_OK,     0, 0);
        // position far past the end appends
        add_row(MODE_ADD_AT,    32'sd0,           32'sh7fff_ffff,   1, 0, ST_OK,     0, 0);
        add_row(MODE_ADD_AT,    32'sh5a5a_5a5a,   32'sd3,           1, 0, ST_OK,     0, 0);
        add_row(MODE_REMOVE,    32'shffff_ffff,   32'shffff_ffff,   1, 1, ST_OK,    -1, 4);
        // fill to capacity
        add_row(MODE_ADD_END,   32'sh0000_0100,   32'sd2,          12, 0, ST_OK,     0, 0);
        add_row(MODE_ADD_FRONT, 32'sd21,          32'sd0,           1, 1, ST_FULL,   0, 16);
        add_row(MODE_ADD_AT,    32'sd22,          32'sd2,           1, 1, ST_FULL,   0, 16);
        // bad position wins over full
        add_row(MODE_ADD_AT,    32'sd23,          -32'sd1,          1, 1, ST_BADPOS, 0, 16);
        add_row(MODE_ADD_END,   32'sd24,          32'sd5,           1, 1, ST_FULL,   0, 16);
        add_row(MODE_REMOVE,    32'sd0,           32'sd0,           3, 0, ST_OK,     0, 0);

        send_idle_pct = 17;
        recv_idle_pct = 85;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            for (r = 0; r < row.reps; r++)
                send_request(row.mode, row.id, row.pos, row.has_fixed, row.fixed);
        end

        // random part: alternate fill and drain sweeps so the store keeps
        // crossing both the full and the empty boundary
        filling = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct = 85;
                recv_idle_pct = 17;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n % SWEEP_LEN == 0)
                filling = ~filling;
            if ($urandom_range(0, 99) < (filling ? 25 : 75)) begin
                mode = MODE_REMOVE;
            end else begin
                case ($urandom_range(0, 2))
                    0:       mode = MODE_ADD_FRONT;
                    1:       mode = MODE_ADD_END;
                    default: mode = MODE_ADD_AT;
                endcase
            end
            // mostly small legal positions, some zero, negative or huge
            roll = $urandom_range(0, 9);
            if (mode != MODE_ADD_AT || roll == 9)
                pos = $urandom;
            else if (roll < 7)
                pos = $urandom_range(1, QUEUE_DEPTH + 2);
            else if (roll == 7)
                pos = 32'sd0;
            else
                pos = {1'b1, 31'($urandom)};
            send_request(mode, $urandom, pos, 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("deque_with_positional_insert_unit_test: done, clean");
        else
            $display("deque_with_positional_insert_unit_test: done, errors");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("deque_with_positional_insert_unit_test: done, errors");
        $finish;
    end

endmodule
